### design/assert_macros.svh
// Assertion macros shared by the verification checkers of the cache.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sacache_pkg.sv
// Shared types, widths and helpers for the two-way set-associative cache.
// No dependencies.
package sacache_pkg;

	localparam int unsigned ADDR_W        = 16;
	localparam int unsigned TAG_W         = 8;
	localparam int unsigned LINE_W        = 32;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned TAG_LSB       = 8;
	localparam int unsigned SET_LSB       = 2;
	localparam int unsigned SET_FIELD_W   = 6;
	localparam int unsigned BIDX_W        = 2;
	localparam int unsigned SET_SPAN      = 1 << SET_FIELD_W;
	localparam int unsigned SET_COUNT_DEF = 64;
	localparam int unsigned WAYS          = 2;

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [TAG_W-1:0]       tag_t;
	typedef logic [LINE_W-1:0]      line_t;
	typedef logic [BYTE_W-1:0]      byte_t;
	typedef logic [BIDX_W-1:0]      bidx_t;
	typedef logic [SET_FIELD_W-1:0] set_field_t;

	// One way of one set as held in the tag/line RAM.
	typedef struct packed {
		tag_t  tag;
		line_t line;
	} entry_t;

	// Byte index 0 selects the most significant byte of the line.
	function automatic byte_t pick_byte(input line_t line, input bidx_t idx);
		byte_t b;
		case (idx)
			2'd0:    b = line[31:24];
			2'd1:    b = line[23:16];
			2'd2:    b = line[15:8];
			default: b = line[7:0];
		endcase
		return b;
	endfunction

endpackage

### design/sacache_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sacache_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the contents from before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/two_way_set_assoc_cache_lru.sv
// Two-way set-associative read-only cache with LRU replacement; uses sacache_pkg, sacache_ram.
// A request goes through the stage 1 registers and RAM read, then through the result register.
// Throughput: one request per clock while out_stall holds no result back, set by a single pass
// through the tag compare between the per-way tag/line RAM read and the result register.
// Reset clears valid bits, LRU bits and the pipeline at once; no clearing pass is needed.
module two_way_set_assoc_cache_lru #(
	parameter int unsigned SET_COUNT = sacache_pkg::SET_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sacache_pkg::addr_t  address,
	input  sacache_pkg::line_t  fill_line,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output sacache_pkg::byte_t  data_byte,
	output logic                way_used
);

	import sacache_pkg::*;

	// The set field of the address has only SET_SPAN values, so sets beyond that
	// are never touched and get no storage.
	localparam int unsigned SETS_USED = (SET_COUNT < SET_SPAN) ? SET_COUNT : SET_SPAN;
	localparam int unsigned SET_IW    = $clog2(SETS_USED);

	typedef logic [SET_IW-1:0] set_idx_t;

	// Map from the raw set field to a set index: the field reduced modulo
	// SET_COUNT, built as a constant table at elaboration.
	set_idx_t set_map [SET_SPAN];

	for (genvar v = 0; v < SET_SPAN; v++) begin : g_set_map
		localparam int unsigned MAP_V = v % SET_COUNT;
		assign set_map[v] = SET_IW'(MAP_V);
	end

	// Handshake control.
	logic     in_fire;
	logic     out_free;
	logic     commit;
	logic     s1_valid;
	logic     out_valid_q;
	set_idx_t in_set;

	// Stage 1 request registers.
	addr_t    addr_s1;
	line_t    fill_s1;
	set_idx_t set_s1;

	// Forwarding of a fill written at the same edge the next request read the RAM.
	logic     fwd_valid_s1;
	logic     fwd_way_s1;
	entry_t   fwd_entry_s1;

	// Lookup state kept in flip-flops so reset clears it at once.
	logic [WAYS-1:0]      valid_q [SETS_USED];
	logic [SETS_USED-1:0] lru_q;

	// Lookup datapath.
	entry_t          rd_entry [WAYS];
	entry_t          way_entry [WAYS];
	logic [WAYS-1:0] match;
	logic [WAYS-1:0] wr_en;
	entry_t          wr_entry;
	tag_t            tag_s1;
	logic            hit_c;
	logic            way_c;
	line_t           line_c;

	// Result register.
	logic  hit_q;
	byte_t byte_q;
	logic  way_q;

	assign out_free = !out_valid_q || !out_stall;
	assign commit   = s1_valid && out_free;
	assign in_stall = s1_valid && !out_free;
	assign in_fire  = in_valid && !in_stall;
	assign in_set   = set_map[address[SET_LSB +: SET_FIELD_W]];
	assign tag_s1   = addr_s1[TAG_LSB +: TAG_W];

	// One RAM per way holds tag and line together. The read is issued as the
	// request is accepted, so the data is ready while the request sits in stage 1.
	for (genvar w = 0; w < WAYS; w++) begin : g_way
		sacache_ram #(
			.WIDTH($bits(entry_t)),
			.DEPTH(SETS_USED)
		) u_ram (
			.clk   (clk),
			.we    (wr_en[w]),
			.waddr (set_s1),
			.wdata (wr_entry),
			.re    (in_fire),
			.raddr (in_set),
			.rdata (rd_entry[w])
		);

		// A fill into this way at the edge this request read the RAM is not in the
		// read data yet, so take it from the forwarding register instead.
		assign way_entry[w] = (fwd_valid_s1 && (fwd_way_s1 == 1'(w))) ? fwd_entry_s1
		                                                              : rd_entry[w];
		assign match[w]     = valid_q[set_s1][w] && (way_entry[w].tag == tag_s1);
		assign wr_en[w]     = commit && !hit_c && (way_c == 1'(w));
	end

	// Tag compare of both ways in parallel. Way 0 wins if both ever matched.
	// On a miss the least recently used way is the victim.
	always_comb begin
		hit_c  = |match;
		if (match[0]) begin
			way_c = 1'b0;
		end else if (match[1]) begin
			way_c = 1'b1;
		end else begin
			way_c = lru_q[set_s1];
		end
		line_c   = hit_c ? way_entry[way_c].line : fill_s1;
		wr_entry = '{tag: tag_s1, line: fill_s1};
	end

	// Stage 1 control and forwarding flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			fwd_valid_s1 <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid     <= 1'b1;
				fwd_valid_s1 <= commit && !hit_c && (in_set == set_s1);
			end else if (commit) begin
				s1_valid <= 1'b0;
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_s1      <= address;
			fill_s1      <= fill_line;
			set_s1       <= in_set;
			fwd_way_s1   <= way_c;
			fwd_entry_s1 <= wr_entry;
		end
	end

	// Valid and LRU update. The way just used becomes most recently used; a hit
	// leaves its valid bit set, a miss sets the valid bit of the filled way.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS_USED; s++) begin
				valid_q[s] <= '0;
			end
			lru_q <= '0;
		end else if (commit) begin
			valid_q[set_s1][way_c] <= 1'b1;
			lru_q[set_s1]          <= !way_c;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q  <= hit_c;
			byte_q <= pick_byte(line_c, addr_s1[BIDX_W-1:0]);
			way_q  <= way_c;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign data_byte = byte_q;
	assign way_used  = way_q;

endmodule

### design/sacache_chk.sv
// Port-level checker for the cache, attached to the top level by a bind.
// Depends on sacache_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sacache_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input sacache_pkg::byte_t data_byte,
	input logic               way_used
);

	// A result held back downstream stays offered.
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

	// A held-back result keeps its fields.
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(hit) && $stable(data_byte) && $stable(way_used), "result changed while stalled")

	// The input side is only held back while a result is stuck at the output.
	`ASSERT_CLK(a_stall_cause, !in_stall || (out_valid && out_stall), "input stalled without output back-pressure")

	// An accepted request reaches the output register when out_stall is low.
	`ASSERT_NEXT(a_result_due, $past(in_valid && !in_stall) && !out_stall, out_valid, "accepted request produced no result")

endmodule

bind two_way_set_assoc_cache_lru sacache_chk u_chk (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-way set-associative LRU cache.
// Depends on sacache_pkg and the two_way_set_assoc_cache_lru top level only.
module tb;
	import sacache_pkg::*;

	localparam int unsigned SETS = SET_COUNT_DEF;
	// Extra wait after the last expected answer, so that a stray answer is caught.
	localparam int unsigned DRAIN_CYCLES = 12;

	// One processor access as it enters the cache.
	typedef struct {
		addr_t address;
		line_t fill;
	} request_t;

	// One lookup answer as it leaves the cache.
	typedef struct {
		logic  hit;
		byte_t data;
		logic  way;
	} lookup_t;

	// Receiver behavior; it is redrawn at random whenever its mode counter runs out.
	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_BURSTY, RX_TOGGLE} rx_mode_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_stall;
	addr_t address   = '0;
	line_t fill_line = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	logic  hit;
	byte_t data_byte;
	logic  way_used;

	two_way_set_assoc_cache_lru #(.SET_COUNT(SETS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.address   (address),
		.fill_line (fill_line),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.data_byte (data_byte),
		.way_used  (way_used)
	);

	always #5 clk = ~clk;

	// Shadow copy of the cache contents, kept in step with every accepted request.
	tag_t  shadow_tag   [2*SETS];
	logic  shadow_valid [2*SETS];
	line_t shadow_line  [2*SETS];
	logic  shadow_lru1  [SETS];

	request_t pending_requests[$];
	lookup_t  expected_lookups[$];
	int unsigned mismatch_count = 0;

	// Looks the address up in the shadow cache, applies the hit or fill exactly as
	// the hardware should, and returns the answer the block must give.
	function automatic lookup_t cache_lookup_predict(input addr_t a, input line_t fill);
		tag_t        t;
		int unsigned s;
		int unsigned e0;
		bidx_t       b;
		logic        h0;
		logic        h1;
		line_t       ln;
		lookup_t     r;
		t  = a[15:8];
		s  = int'(a[7:2]) % SETS;
		b  = a[1:0];
		e0 = s * 2;
		h0 = shadow_valid[e0] && shadow_tag[e0] == t;
		h1 = shadow_valid[e0+1] && shadow_tag[e0+1] == t;
		if (h0) begin
			// Way 0 takes priority should both ways ever hold the tag.
			r.hit = 1'b1;
			r.way = 1'b0;
			ln = shadow_line[e0];
			shadow_lru1[s] = 1'b1;
		end else if (h1) begin
			r.hit = 1'b1;
			r.way = 1'b1;
			ln = shadow_line[e0+1];
			shadow_lru1[s] = 1'b0;
		end else begin
			// Miss: the least recently used way is refilled and becomes most recent.
			r.hit = 1'b0;
			r.way = shadow_lru1[s];
			shadow_tag[e0+r.way]   = t;
			shadow_valid[e0+r.way] = 1'b1;
			shadow_line[e0+r.way]  = fill;
			shadow_lru1[s] = ~r.way;
			ln = fill;
		end
		// Byte index 0 is the most significant byte of the line.
		r.data = byte_t'(ln >> (8 * (3 - int'(b))));
		return r;
	endfunction

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic queue_access(input tag_t t, input set_field_t s, input bidx_t b,
			input line_t fill);
		request_t req;
		req.address = {t, s, b};
		req.fill = fill;
		pending_requests.push_back(req);
	endtask

	// Driver: changes inputs on the falling edge. A request stays on the bus until
	// an edge takes it; the sender then works in bursts separated by random gaps.
	logic        taken = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(negedge clk) begin : drive_requests
		request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !taken) begin
			// Held by backpressure: payload stays put.
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_requests.size() != 0) begin
			req = pending_requests.pop_front();
			address   <= req.address;
			fill_line <= req.fill;
			in_valid  <= 1'b1;
			if (burst_left <= 1) begin
				// Long bursts with no gap now and then give back-to-back stretches.
				burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 20);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver stall pattern, also changed on the falling edge.
	rx_mode_t    rx_mode = RX_FREE;
	int unsigned rx_mode_left = 0;
	int unsigned rx_hold_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_mode_left <= $urandom_range(20, 80);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_FREE: begin
					out_stall <= 1'b0;
				end
				RX_RANDOM: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				RX_BURSTY: begin
					if (rx_hold_left != 0) begin
						out_stall <= 1'b1;
						rx_hold_left <= rx_hold_left - 1;
					end else if ($urandom_range(0, 5) == 0) begin
						out_stall <= 1'b1;
						rx_hold_left <= $urandom_range(1, 8);
					end else begin
						out_stall <= 1'b0;
					end
				end
				default: begin
					out_stall <= ~out_stall;
				end
			endcase
		end
	end

	// Monitor: on each rising edge, first record a request that the edge takes,
	// then check an answer that the edge takes against the oldest expectation.
	always @(posedge clk) begin : watch_ports
		lookup_t want;
		taken <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			expected_lookups.push_back(cache_lookup_predict(address, fill_line));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lookups.size() == 0) begin
				note_failure($sformatf("unexpected answer hit=%0b data=%02h way=%0b",
					hit, data_byte, way_used));
			end else begin
				want = expected_lookups.pop_front();
				if (hit !== want.hit || data_byte !== want.data || way_used !== want.way)
					note_failure($sformatf(
						"answer mismatch: expected hit=%0b data=%02h way=%0b, got hit=%0b data=%02h way=%0b",
						want.hit, want.data, want.way, hit, data_byte, way_used));
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		tag_t       t;
		set_field_t s;
		for (int i = 0; i < 2 * SETS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_tag[i]   = '0;
			shadow_line[i]  = '0;
		end
		for (int i = 0; i < SETS; i++)
			shadow_lru1[i] = 1'b0;

		// Directed part. Tag zero on an empty set must miss even though the tag
		// field matches nothing written yet; the lowest and highest addresses
		// come first with all-zero and all-one lines.
		queue_access(8'h00, 6'd0, 2'd0, 32'h0000_0000);
		queue_access(8'hFF, 6'd63, 2'd3, 32'hFFFF_FFFF);
		// Hit on way 0, then a second tag fills way 1.
		queue_access(8'hFF, 6'd63, 2'd0, 32'h1234_5678);
		queue_access(8'h00, 6'd63, 2'd1, 32'hA5A5_5A5A);
		// Touch way 0 so way 1 becomes least recent, then evict way 1.
		queue_access(8'hFF, 6'd63, 2'd2, 32'h0);
		queue_access(8'h80, 6'd63, 2'd3, 32'h5A5A_A5A5);
		// The next miss must take way 0, evicting the all-one line.
		queue_access(8'h00, 6'd63, 2'd0, 32'h1111_1111);
		queue_access(8'hFF, 6'd63, 2'd1, 32'h1122_3344);
		// Every byte index of a known line, hitting on way 1 and then way 0.
		for (int b = 0; b < 4; b++)
			queue_access(8'hFF, 6'd63, bidx_t'(b), 32'h0);
		for (int b = 0; b < 4; b++)
			queue_access(8'h00, 6'd63, bidx_t'(b), 32'hFFFF_FFFF);
		// Hits on the set-0 line, and a neighbor tag that differs in one bit fills way 1 and then hits.
		queue_access(8'h00, 6'd0, 2'd3, 32'hDEAD_BEEF);
		queue_access(8'h01, 6'd0, 2'd2, 32'hC0FF_EE00);
		queue_access(8'h01, 6'd0, 2'd1, 32'h0);
		queue_access(8'h00, 6'd0, 2'd0, 32'h0);

		// Random part. Most requests draw from a few hot sets and a small tag pool
		// so hits, refills and evictions of either way all happen often; the rest
		// are fully random addresses.
		for (int n = 0; n < 700; n++) begin
			if ($urandom_range(0, 6) == 0) begin
				t = tag_t'($urandom);
				s = set_field_t'($urandom);
			end else begin
				s = ($urandom_range(0, 3) == 0) ? set_field_t'($urandom)
					: set_field_t'($urandom_range(0, 7) * 9);
				case ($urandom_range(0, 4))
					0: t = 8'h00;
					1: t = 8'hFF;
					2: t = 8'h5A;
					3: t = 8'hA5;
					default: t = tag_t'($urandom);
				endcase
			end
			queue_access(t, s, bidx_t'($urandom), line_t'($urandom));
		end

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_lookups.size() != 0)
			@(negedge clk);
		// Any answer that shows up now has no request behind it.
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0) begin
			$display("PASS two_way_set_assoc_cache_lru");
		end else begin
			$display("FAIL two_way_set_assoc_cache_lru");
		end
		$finish;
	end

	// Hard stop if the block hangs; far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAIL two_way_set_assoc_cache_lru");
		$finish;
	end

endmodule
